[rtl/fast9_pkg.sv]
`default_nettype none
package fast9_pkg;
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int CORNER_LIMIT_DEF = 256;
    localparam int LINES   = 6;
    localparam int RING    = 16;
    localparam int ARC_LEN = 9;
    localparam int RADIUS  = 3;
    localparam int MAX_HEIGHT = 1024;

    localparam logic [0:0] KIND_CORNER  = 1'b0;
    localparam logic [0:0] KIND_SUMMARY = 1'b1;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WIDTH     = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;

    typedef logic [7:0] pix_t;
    typedef pix_t [6:0][6:0] win_t;

    // Circle offsets as {dx, dy}, each plus RADIUS.
    function automatic logic [2:0] ring_x(input int i);
        logic [2:0] t [16];
        t = '{3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
              3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2};
        return t[i];
    endfunction

    function automatic logic [2:0] ring_y(input int i);
        logic [2:0] t [16];
        t = '{3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
              3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
        return t[i];
    endfunction
endpackage
`default_nettype wire

[rtl/fast9_test.sv]
`default_nettype none
// Registered corner test on a full window: stage one compares, stage two
// finds the arc and sums the score.
module fast9_test
    import fast9_pkg::*;
(
    input  wire         aclk,
    input  wire         en,
    input  win_t        win,
    input  wire [7:0]   thr,
    output logic        corner,
    output logic [11:0] score
);
    logic [15:0] hi_reg, lo_reg;
    logic [7:0]  ex_reg [16];
    logic [15:0] hi_next, lo_next;
    logic [7:0]  ex_next [16];

    // Stage one: per-pixel brighter, darker and excess.
    always_comb begin
        logic [8:0] c, p, d, t;
        c = {1'b0, win[RADIUS][RADIUS]};
        t = {1'b0, thr};
        for (int i = 0; i < RING; i++) begin
            p = {1'b0, win[ring_y(i)][ring_x(i)]};
            hi_next[i] = p > c + t;
            lo_next[i] = p + t < c;
            d = (p > c) ? p - c : c - p;
            ex_next[i] = (d > t) ? 8'(d - t) : 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
            ex_reg <= ex_next;
        end
    end

    // Stage two: any run of nine in the wrapped circle, and the score sum
    // as a balanced adder tree.
    always_comb begin
        logic [31:0] hh, ll;
        logic found;
        logic [8:0]  s2 [8];
        logic [9:0]  s4 [4];
        logic [10:0] s8 [2];
        hh = {hi_reg, hi_reg};
        ll = {lo_reg, lo_reg};
        found = 1'b0;
        for (int s = 0; s < RING; s++) begin
            found = found | (&hh[s +: ARC_LEN]) | (&ll[s +: ARC_LEN]);
        end
        corner = found;
        for (int i = 0; i < 8; i++) s2[i] = {1'b0, ex_reg[2*i]} + {1'b0, ex_reg[2*i+1]};
        for (int i = 0; i < 4; i++) s4[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        for (int i = 0; i < 2; i++) s8[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
        score = {1'b0, s8[0]} + {1'b0, s8[1]};
    end
endmodule
`default_nettype wire

[rtl/fast9_corner_detector.sv]
`default_nettype none
// Channel | Port group        | Contents
// input   | s_axis_t*         | tdata[7:0] pixel
// output  | m_axis_t*         | tdata: corner_x, corner_y, score, corner_total; tuser kind; tlast
// config  | cfg_we/addr/wdata | threshold, image_width, image_height
// One pixel per cycle while the output is not stalled. A pixel is read from the
// line memory at the edge that accepts it; it then shifts into the window, is
// compared into the test's stage one registers and lands in the output register.
// A corner at the end of a frame is followed by the frame summary as a second
// result in the output slot. Reset clears counters and window; the line memory needs
// no clearing. An output stall stops the whole pipeline.
module fast9_corner_detector
    import fast9_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int CORNER_LIMIT = CORNER_LIMIT_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [7:0]   s_axis_tdata,   // pixel
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // corner_x, corner_y, score, corner_total
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast,
    input  wire         cfg_we,
    input  wire [1:0]   cfg_addr,
    input  wire [10:0]  cfg_wdata
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LW = 8 * LINES;
    localparam int CLW = $clog2(CORNER_LIMIT + 1);

    logic [7:0]  thr_reg;
    logic [10:0] wid_reg, hgt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 8'd20;
            wid_reg <= 11'd320;
            hgt_reg <= 11'd240;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_THRESHOLD: thr_reg <= cfg_wdata[7:0];
                REG_WIDTH:     wid_reg <= cfg_wdata;
                REG_HEIGHT:    hgt_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective frame size.
    logic [12:0] w_eff, h_eff;
    always_comb begin
        w_eff = (wid_reg < 11'd7) ? 13'd7 :
                (13'(wid_reg) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(wid_reg);
        h_eff = (hgt_reg < 11'd7) ? 13'd7 :
                (13'(hgt_reg) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(hgt_reg);
    end

    // Output skid: a slot of two results, drained one per cycle while m_axis_tready is high.
    logic [1:0]  ocnt_reg;
    logic [47:0] od_reg [2];
    logic        ou_reg [2];
    logic        ol_reg [2];
    logic        adv;
    assign adv = (ocnt_reg == 2'd0) || (ocnt_reg == 2'd1 && m_axis_tready);
    // No transaction is taken while reset is held.
    assign s_axis_tready = adv && aresetn;
    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    // Stage 0: counters and line memory read.
    logic [12:0] col_reg, row_reg;
    logic [CLW-1:0] found_reg;
    logic [LW-1:0] lmem [MAX_WIDTH];
    logic [LW-1:0] lrd_reg;
    logic [AW-1:0] cidx;
    assign cidx = (col_reg < 13'(MAX_WIDTH)) ? col_reg[AW-1:0] : AW'(MAX_WIDTH - 1);

    logic row_end, frame_end;
    assign row_end = col_reg >= w_eff - 13'd1;
    assign frame_end = row_end && row_reg >= h_eff - 13'd1;

    always_ff @(posedge aclk) begin
        if (acc) begin
            lrd_reg <= lmem[cidx];
        end
    end

    // Stage 1 registers.
    logic        v1_reg, test1_reg, fe1_reg;
    logic [7:0]  pix1_reg;
    logic [AW-1:0] cidx1_reg;
    logic [9:0]  x1_reg, y1_reg;
    // Stage 2/3.
    logic        v2_reg, test2_reg, fe2_reg;
    logic [9:0]  x2_reg, y2_reg;
    logic        v3_reg, test3_reg, fe3_reg;
    logic [9:0]  x3_reg, y3_reg;
    win_t        win_reg;

    logic test0;
    assign test0 = col_reg >= 13'd6 && row_reg >= 13'd6 && col_reg < w_eff &&
                   row_reg < h_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= acc;
            if (acc) begin
                if (frame_end) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else if (row_end) begin
                    col_reg <= '0;
                    row_reg <= row_reg + 13'd1;
                end else begin
                    col_reg <= col_reg + 13'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && acc) begin
            pix1_reg  <= s_axis_tdata;
            cidx1_reg <= cidx;
            test1_reg <= test0;
            fe1_reg   <= frame_end;
            x1_reg    <= 10'(col_reg - 13'd3);
            y1_reg    <= 10'(row_reg - 13'd3);
        end
    end

    // Stage 1: shift window, write back shifted column.
    always_ff @(posedge aclk) begin
        if (adv && v1_reg) begin
            lmem[cidx1_reg] <= {lrd_reg[LW-9:0], pix1_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (adv && v1_reg) begin
            for (int r = 0; r < 7; r++) begin
                for (int c = 0; c < 6; c++) win_reg[r][c] <= win_reg[r][c+1];
            end
            for (int r = 0; r < LINES; r++) win_reg[r][6] <= lrd_reg[8*(5-r) +: 8];
            win_reg[6][6] <= pix1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            test2_reg <= test1_reg; fe2_reg <= fe1_reg;
            x2_reg <= x1_reg; y2_reg <= y1_reg;
            test3_reg <= test2_reg; fe3_reg <= fe2_reg;
            x3_reg <= x2_reg; y3_reg <= y2_reg;
        end
    end

    logic        corner;
    logic [11:0] score;
    fast9_test u_test (
        .aclk  (aclk),
        .en    (adv),
        .win   (win_reg),
        .thr   (thr_reg),
        .corner(corner),
        .score (score)
    );

    // Stage 3: results into the output slot.
    logic hit;
    assign hit = v3_reg && test3_reg && corner && (found_reg < CLW'(CORNER_LIMIT));
    logic [CLW-1:0] tot;
    assign tot = found_reg + CLW'(hit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= '0;
            ocnt_reg  <= '0;
        end else begin
            if (adv) begin
                if (v3_reg) found_reg <= fe3_reg ? '0 : tot;
                ocnt_reg <= 2'(v3_reg && (hit || fe3_reg)) + 2'(v3_reg && hit && fe3_reg);
            end else if (m_axis_tvalid && m_axis_tready) begin
                ocnt_reg <= ocnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            od_reg[0] <= hit ? {7'd0, 9'd0, score, y3_reg, x3_reg}
                             : {7'd0, 9'(tot), 32'd0};
            ou_reg[0] <= hit ? KIND_CORNER : KIND_SUMMARY;
            ol_reg[0] <= !(hit && fe3_reg);
            od_reg[1] <= {7'd0, 9'(tot), 32'd0};
            ou_reg[1] <= KIND_SUMMARY;
            ol_reg[1] <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            od_reg[0] <= od_reg[1];
            ou_reg[0] <= ou_reg[1];
            ol_reg[0] <= ol_reg[1];
        end
    end

    assign m_axis_tvalid = ocnt_reg != 2'd0;
    assign m_axis_tdata  = {7'd0, od_reg[0][40:0]};
    assign m_axis_tuser  = ou_reg[0];
    assign m_axis_tlast  = ol_reg[0];

    // Checks.
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn) ocnt_reg != 2'd3)
        else $error("output slot overfilled");
    a_lim: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg <= CLW'(CORNER_LIMIT)) else $error("corner count past limit");
    a_two: assert property (@(posedge aclk) disable iff (!aresetn)
        ocnt_reg == 2'd2 |-> !m_axis_tlast && m_axis_tuser == KIND_CORNER)
        else $error("pair must start with a corner");
endmodule
`default_nettype wire
